@@ rtl/core/tbps_pkg.sv @@
package tbps_pkg;

  localparam int MAX_PROCESSES = 64;
  localparam int PRIORITY_BITS = 8;

  localparam int ID_W   = (MAX_PROCESSES > 2) ? $clog2(MAX_PROCESSES) : 1;
  localparam int PRIO_W = PRIORITY_BITS;

  typedef logic [ID_W-1:0]   slot_id_t;
  typedef logic [PRIO_W-1:0] prio_t;

  localparam slot_id_t LAST_ID = slot_id_t'(MAX_PROCESSES - 1);
  localparam logic [MAX_PROCESSES-1:0] VLD_RESET = MAX_PROCESSES'(1);

  // Request action codes
  localparam logic [2:0] ACT_CREATE    = 3'd0;
  localparam logic [2:0] ACT_REMOVE    = 3'd1;
  localparam logic [2:0] ACT_SET_STATE = 3'd2;
  localparam logic [2:0] ACT_SCHEDULE  = 3'd3;
  localparam logic [2:0] ACT_CHARGE    = 3'd4;

  // Result status codes
  localparam logic [2:0] STS_OK         = 3'd0;
  localparam logic [2:0] STS_FULL       = 3'd1;
  localparam logic [2:0] STS_NO_PROC    = 3'd2;
  localparam logic [2:0] STS_NO_READY   = 3'd3;
  localparam logic [2:0] STS_CUR_REMOVE = 3'd4;

  // Run states
  localparam logic [1:0] RS_READY = 2'd0;
  localparam logic [1:0] RS_SLEEP = 2'd1;
  localparam logic [1:0] RS_RUN   = 2'd2;

  typedef struct packed {
    logic [2:0] action;
    logic [5:0] target_id;
    logic [7:0] new_priority;
    logic [1:0] run_state_in;
  } tbps_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] result_id;
    logic [7:0] result_budget;
  } tbps_rsp_t;

  typedef struct packed {
    logic [1:0] run_state;
    prio_t      prio;
    prio_t      budget;
  } slot_t;

  typedef struct packed {
    logic     en;
    slot_id_t addr;
    slot_t    data;
  } slot_wr_t;

  typedef struct packed {
    logic     set;
    logic     clr;
    slot_id_t addr;
  } vld_upd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FIND,
    ST_MODIFY,
    ST_CUR_SET,
    ST_SCAN,
    ST_WIN,
    ST_EMIT
  } sched_state_t;

  function automatic logic [1:0] sat_state(logic [1:0] s);
    return (s > RS_RUN) ? RS_RUN : s;
  endfunction

  function automatic prio_t prio_from_in(logic [7:0] v);
    logic [PRIO_W+7:0] ext;
    ext = {{PRIO_W{1'b0}}, v};
    return ext[PRIO_W-1:0];
  endfunction

  function automatic logic [7:0] bud_to_out(prio_t b);
    logic [PRIO_W+7:0] ext;
    ext = {8'b0, b};
    return ext[7:0];
  endfunction

  function automatic slot_id_t id_from_in(logic [5:0] v);
    logic [ID_W+5:0] ext;
    ext = {{ID_W{1'b0}}, v};
    return ext[ID_W-1:0];
  endfunction

  function automatic logic [5:0] id_to_out(slot_id_t id);
    logic [ID_W+5:0] ext;
    ext = {6'b0, id};
    return ext[5:0];
  endfunction

endpackage

@@ rtl/core/tbps_slot_store.sv @@
module tbps_slot_store (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                rd_en,
  input  tbps_pkg::slot_id_t                  rd_addr,
  input  tbps_pkg::slot_wr_t                  wr,
  input  tbps_pkg::vld_upd_t                  vld,
  output tbps_pkg::slot_t                     rd_entry,
  output logic [tbps_pkg::MAX_PROCESSES-1:0]  slot_vld
);

  tbps_pkg::slot_t    mem_r [tbps_pkg::MAX_PROCESSES];
  tbps_pkg::slot_t    rdata_r;
  tbps_pkg::slot_id_t ra_r;
  logic [tbps_pkg::MAX_PROCESSES-1:0] vld_r;
  logic               init0_r;

  // Slot 0 holds its reset contents until first written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= tbps_pkg::VLD_RESET;
      init0_r <= 1'b1;
    end else begin
      if (vld.set) begin
        vld_r[vld.addr] <= 1'b1;
      end
      if (vld.clr) begin
        vld_r[vld.addr] <= 1'b0;
      end
      if (wr.en && (wr.addr == '0)) begin
        init0_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rdata_r <= mem_r[rd_addr];
      ra_r    <= rd_addr;
    end
  end

  // A free slot always reads as all zeros.
  always_comb begin
    if (!vld_r[ra_r]) begin
      rd_entry = '0;
    end else if ((ra_r == '0) && init0_r) begin
      rd_entry.run_state = tbps_pkg::RS_RUN;
      rd_entry.prio      = tbps_pkg::prio_t'(1);
      rd_entry.budget    = tbps_pkg::prio_t'(1);
    end else begin
      rd_entry = rdata_r;
    end
  end

  assign slot_vld = vld_r;

endmodule

@@ rtl/core/tick_budget_process_scheduler_top.sv @@
// Tick-budget process scheduler. The slot table (run state, priority,
// budget) lives in one synchronous RAM with a registered read; valid marks
// are flops. One request is worked at a time: create scans the valid marks
// from slot 1 upward, set state and charge do one read-modify-write, and
// remove of a non-current slot only clears its valid mark. Schedule, and
// remove of the current slot, run one RAM pass over all slots at one slot
// per cycle; if no ready slot has budget left, a second pass refills every
// ready slot from its priority and picks again. A finished result sits in
// an output register, so a new request is taken while the previous result
// waits for out_ready.
module tick_budget_process_scheduler_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tbps_pkg::tbps_req_t in_req,
  output logic                out_valid,
  input  logic                out_ready,
  output tbps_pkg::tbps_rsp_t out_rsp
);

  tbps_pkg::sched_state_t state_r, state_nxt;
  tbps_pkg::tbps_req_t    req_r, req_nxt;
  tbps_pkg::tbps_rsp_t    res_r, res_nxt;
  tbps_pkg::tbps_rsp_t    out_rsp_r, out_rsp_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             rs_eff_r, rs_eff_nxt;
  logic                   rm_cur_r, rm_cur_nxt;
  tbps_pkg::slot_id_t     current_id_r, current_id_nxt;
  tbps_pkg::slot_id_t     idx_r, idx_nxt;
  logic                   iss_done_r, iss_done_nxt;
  logic                   sv_r, sv_nxt;
  tbps_pkg::slot_id_t     sidx_r, sidx_nxt;
  logic                   pass_r, pass_nxt;
  logic                   best_found_r, best_found_nxt;
  tbps_pkg::slot_id_t     best_id_r, best_id_nxt;
  tbps_pkg::prio_t        best_b_r, best_b_nxt;
  tbps_pkg::prio_t        best_prio_r, best_prio_nxt;
  tbps_pkg::prio_t        cur_bud_r, cur_bud_nxt;

  logic                   rd_en;
  tbps_pkg::slot_id_t     rd_addr;
  tbps_pkg::slot_wr_t     wr;
  tbps_pkg::vld_upd_t     vld;
  tbps_pkg::slot_t        rd_entry;
  logic [tbps_pkg::MAX_PROCESSES-1:0] slot_vld;

  tbps_pkg::slot_id_t     tgt_idx;
  logic                   tgt_ok;
  logic                   cur_ok;
  logic                   is_ready;
  tbps_pkg::prio_t        eff_bud;
  tbps_pkg::prio_t        cur_bud_now;
  tbps_pkg::prio_t        charged;
  logic                   cand;
  logic                   scan_start;

  tbps_slot_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .wr       (wr),
    .vld      (vld),
    .rd_entry (rd_entry),
    .slot_vld (slot_vld)
  );

  assign tgt_idx = tbps_pkg::id_from_in(req_r.target_id);
  assign tgt_ok  = (32'(req_r.target_id) < 32'(tbps_pkg::MAX_PROCESSES)) && slot_vld[tgt_idx];
  assign cur_ok  = slot_vld[current_id_r];

  // Scan datapath: the refill pass sees every ready slot's budget as its priority.
  assign is_ready    = (rd_entry.run_state == tbps_pkg::RS_READY);
  assign eff_bud     = (pass_r && is_ready) ? rd_entry.prio : rd_entry.budget;
  assign cand        = sv_r && is_ready && (eff_bud > best_b_r);
  assign cur_bud_now = (sv_r && pass_r && (sidx_r == current_id_r)) ? eff_bud : cur_bud_r;
  assign charged     = (rd_entry.budget == '0) ? '0 : rd_entry.budget - tbps_pkg::prio_t'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tbps_pkg::ST_IDLE;
      out_valid_r  <= 1'b0;
      current_id_r <= '0;
      sv_r         <= 1'b0;
      iss_done_r   <= 1'b0;
      pass_r       <= 1'b0;
      best_found_r <= 1'b0;
      rm_cur_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      current_id_r <= current_id_nxt;
      sv_r         <= sv_nxt;
      iss_done_r   <= iss_done_nxt;
      pass_r       <= pass_nxt;
      best_found_r <= best_found_nxt;
      rm_cur_r     <= rm_cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    res_r       <= res_nxt;
    out_rsp_r   <= out_rsp_nxt;
    rs_eff_r    <= rs_eff_nxt;
    idx_r       <= idx_nxt;
    sidx_r      <= sidx_nxt;
    best_id_r   <= best_id_nxt;
    best_b_r    <= best_b_nxt;
    best_prio_r <= best_prio_nxt;
    cur_bud_r   <= cur_bud_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    res_nxt        = res_r;
    out_rsp_nxt    = out_rsp_r;
    out_valid_nxt  = out_valid_r;
    rs_eff_nxt     = rs_eff_r;
    rm_cur_nxt     = rm_cur_r;
    current_id_nxt = current_id_r;
    idx_nxt        = idx_r;
    iss_done_nxt   = iss_done_r;
    sv_nxt         = 1'b0;
    sidx_nxt       = sidx_r;
    pass_nxt       = pass_r;
    best_found_nxt = best_found_r;
    best_id_nxt    = best_id_r;
    best_b_nxt     = best_b_r;
    best_prio_nxt  = best_prio_r;
    cur_bud_nxt    = cur_bud_r;
    rd_en          = 1'b0;
    rd_addr        = current_id_r;
    wr             = '0;
    vld            = '0;
    scan_start     = 1'b0;
    in_ready       = 1'b0;

    // Drop the output once the result is taken downstream.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      tbps_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt   = in_req;
          state_nxt = tbps_pkg::ST_DECODE;
        end
      end

      tbps_pkg::ST_DECODE: begin
        case (req_r.action)
          tbps_pkg::ACT_CREATE: begin
            idx_nxt   = tbps_pkg::slot_id_t'(1);
            state_nxt = tbps_pkg::ST_FIND;
          end
          tbps_pkg::ACT_REMOVE: begin
            if (!tgt_ok) begin
              res_nxt   = '{status: tbps_pkg::STS_NO_PROC, result_id: '0, result_budget: '0};
              state_nxt = tbps_pkg::ST_EMIT;
            end else if (tgt_idx == current_id_r) begin
              // Exclude the running slot, reschedule, then free it.
              rs_eff_nxt = tbps_pkg::RS_RUN;
              rm_cur_nxt = 1'b1;
              rd_en      = 1'b1;
              rd_addr    = current_id_r;
              state_nxt  = tbps_pkg::ST_CUR_SET;
            end else begin
              vld.clr   = 1'b1;
              vld.addr  = tgt_idx;
              res_nxt   = '{status: tbps_pkg::STS_OK, result_id: req_r.target_id,
                            result_budget: '0};
              state_nxt = tbps_pkg::ST_EMIT;
            end
          end
          tbps_pkg::ACT_SET_STATE: begin
            if (!tgt_ok) begin
              res_nxt   = '{status: tbps_pkg::STS_NO_PROC, result_id: '0, result_budget: '0};
              state_nxt = tbps_pkg::ST_EMIT;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = tgt_idx;
              state_nxt = tbps_pkg::ST_MODIFY;
            end
          end
          tbps_pkg::ACT_SCHEDULE: begin
            rs_eff_nxt = tbps_pkg::sat_state(req_r.run_state_in);
            rm_cur_nxt = 1'b0;
            if (cur_ok) begin
              rd_en     = 1'b1;
              rd_addr   = current_id_r;
              state_nxt = tbps_pkg::ST_CUR_SET;
            end else begin
              scan_start = 1'b1;
            end
          end
          tbps_pkg::ACT_CHARGE: begin
            if (cur_ok) begin
              rd_en     = 1'b1;
              rd_addr   = current_id_r;
              state_nxt = tbps_pkg::ST_MODIFY;
            end else begin
              res_nxt   = '{status: tbps_pkg::STS_NO_PROC, result_id: '0, result_budget: '0};
              state_nxt = tbps_pkg::ST_EMIT;
            end
          end
          default: begin
            // Unknown action: no result.
            state_nxt = tbps_pkg::ST_IDLE;
          end
        endcase
      end

      tbps_pkg::ST_FIND: begin
        // Walk the valid marks for the lowest free slot above slot 0.
        if (!slot_vld[idx_r]) begin
          wr.en             = 1'b1;
          wr.addr           = idx_r;
          wr.data.run_state = tbps_pkg::RS_READY;
          wr.data.prio      = tbps_pkg::prio_from_in(req_r.new_priority);
          wr.data.budget    = tbps_pkg::prio_from_in(req_r.new_priority);
          vld.set           = 1'b1;
          vld.addr          = idx_r;
          res_nxt   = '{status: tbps_pkg::STS_OK, result_id: tbps_pkg::id_to_out(idx_r),
                        result_budget: tbps_pkg::bud_to_out(
                          tbps_pkg::prio_from_in(req_r.new_priority))};
          state_nxt = tbps_pkg::ST_EMIT;
        end else if (idx_r == tbps_pkg::LAST_ID) begin
          res_nxt   = '{status: tbps_pkg::STS_FULL, result_id: '0, result_budget: '0};
          state_nxt = tbps_pkg::ST_EMIT;
        end else begin
          idx_nxt = idx_r + tbps_pkg::slot_id_t'(1);
        end
      end

      tbps_pkg::ST_MODIFY: begin
        wr.en = 1'b1;
        wr.data.prio = rd_entry.prio;
        if (req_r.action == tbps_pkg::ACT_SET_STATE) begin
          wr.addr           = tgt_idx;
          wr.data.run_state = tbps_pkg::sat_state(req_r.run_state_in);
          wr.data.budget    = rd_entry.budget;
          res_nxt = '{status: tbps_pkg::STS_OK, result_id: req_r.target_id,
                      result_budget: tbps_pkg::bud_to_out(rd_entry.budget)};
        end else begin
          wr.addr           = current_id_r;
          wr.data.run_state = rd_entry.run_state;
          wr.data.budget    = charged;
          res_nxt = '{status: tbps_pkg::STS_OK, result_id: tbps_pkg::id_to_out(current_id_r),
                      result_budget: tbps_pkg::bud_to_out(charged)};
        end
        state_nxt = tbps_pkg::ST_EMIT;
      end

      tbps_pkg::ST_CUR_SET: begin
        wr.en             = 1'b1;
        wr.addr           = current_id_r;
        wr.data.run_state = rs_eff_r;
        wr.data.prio      = rd_entry.prio;
        wr.data.budget    = rd_entry.budget;
        scan_start        = 1'b1;
      end

      tbps_pkg::ST_SCAN: begin
        // Issue one read per cycle; evaluate the slot read the cycle before.
        rd_en    = !iss_done_r;
        rd_addr  = idx_r;
        sv_nxt   = !iss_done_r;
        sidx_nxt = idx_r;
        if (!iss_done_r) begin
          if (idx_r == tbps_pkg::LAST_ID) begin
            iss_done_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + tbps_pkg::slot_id_t'(1);
          end
        end
        if (sv_r) begin
          if (pass_r && is_ready) begin
            wr.en             = 1'b1;
            wr.addr           = sidx_r;
            wr.data.run_state = tbps_pkg::RS_READY;
            wr.data.prio      = rd_entry.prio;
            wr.data.budget    = rd_entry.prio;
          end
          if (cand) begin
            best_found_nxt = 1'b1;
            best_id_nxt    = sidx_r;
            best_b_nxt     = eff_bud;
            best_prio_nxt  = rd_entry.prio;
          end
          cur_bud_nxt = cur_bud_now;
          if (sidx_r == tbps_pkg::LAST_ID) begin
            if (best_found_r || cand) begin
              state_nxt = tbps_pkg::ST_WIN;
            end else if (!pass_r) begin
              // Nothing with budget left: refill and pick again.
              pass_nxt     = 1'b1;
              idx_nxt      = '0;
              iss_done_nxt = 1'b0;
              sv_nxt       = 1'b0;
            end else begin
              if (rm_cur_r) begin
                vld.clr  = 1'b1;
                vld.addr = current_id_r;
              end
              res_nxt = '{status: tbps_pkg::STS_NO_READY,
                          result_id: tbps_pkg::id_to_out(current_id_r),
                          result_budget: rm_cur_r ? 8'd0 : tbps_pkg::bud_to_out(cur_bud_now)};
              state_nxt = tbps_pkg::ST_EMIT;
            end
          end
        end
      end

      tbps_pkg::ST_WIN: begin
        wr.en             = 1'b1;
        wr.addr           = best_id_r;
        wr.data.run_state = tbps_pkg::RS_RUN;
        wr.data.prio      = best_prio_r;
        wr.data.budget    = best_b_r;
        current_id_nxt    = best_id_r;
        if (rm_cur_r) begin
          vld.clr  = 1'b1;
          vld.addr = current_id_r;
        end
        res_nxt = '{status: rm_cur_r ? tbps_pkg::STS_CUR_REMOVE : tbps_pkg::STS_OK,
                    result_id: tbps_pkg::id_to_out(best_id_r),
                    result_budget: tbps_pkg::bud_to_out(best_b_r)};
        state_nxt = tbps_pkg::ST_EMIT;
      end

      tbps_pkg::ST_EMIT: begin
        // Hold the result until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_rsp_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = tbps_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = tbps_pkg::ST_IDLE;
      end
    endcase

    if (scan_start) begin
      idx_nxt        = '0;
      iss_done_nxt   = 1'b0;
      sv_nxt         = 1'b0;
      pass_nxt       = 1'b0;
      best_found_nxt = 1'b0;
      best_b_nxt     = '0;
      cur_bud_nxt    = '0;
      state_nxt      = tbps_pkg::ST_SCAN;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // A RAM write never lands on the entry being read in the same cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (wr.en && rd_en) |-> (wr.addr != rd_addr))
    else $error("tbps: RAM read and write collide on one slot");

  // Create never hands out slot 0.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tbps_pkg::ST_FIND && vld.set) |-> (idx_r != '0))
    else $error("tbps: create claimed slot 0");

  // The winner step only follows a scan that found a candidate.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tbps_pkg::ST_WIN) |-> (best_found_r && $past(state_r == tbps_pkg::ST_SCAN)))
    else $error("tbps: winner without a candidate");

  // After a pick, the new current slot is a live slot.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tbps_pkg::ST_WIN) |=> slot_vld[current_id_r])
    else $error("tbps: current slot is free after a pick");

endmodule

@@ tb/sv/tb_tick_budget_process_scheduler_top.sv @@
module tb_tick_budget_process_scheduler_top;
  import tbps_pkg::*;

  // Action codes the block ignores, and the run state that saturates to excluded.
  localparam logic [2:0] ACT_IGNORED_LO = 3'd5;
  localparam logic [2:0] ACT_IGNORED_HI = 3'd7;
  localparam logic [1:0] RS_OVER        = 2'd3;

  // Request mixes for the random part.
  localparam int MIX_NORMAL = 0;
  localparam int MIX_FILL   = 1;
  localparam int MIX_DRAIN  = 2;

  localparam int CHUNK_ITEMS = 100;
  localparam int CHUNKS      = 10;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  tbps_req_t in_req;
  logic      out_valid;
  logic      out_ready;
  tbps_rsp_t out_rsp;

  tick_budget_process_scheduler_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rsp  (out_rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up long after the slowest legal run would have ended.
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Slot table mirror: updated once per accepted request, in acceptance order.
  // ---------------------------------------------------------------------------
  bit         tbl_valid  [MAX_PROCESSES];
  logic [1:0] tbl_state  [MAX_PROCESSES];
  prio_t      tbl_prio   [MAX_PROCESSES];
  prio_t      tbl_budget [MAX_PROCESSES];
  slot_id_t   tbl_cur;

  tbps_rsp_t  rsp_due_q[$];   // responses owed by the block, oldest first
  int         err_count = 0;
  int         rx_count  = 0;
  int         burst_left = 0;

  typedef struct {
    tbps_req_t req;
    bit        typed;   // response written into the row, not predicted
    tbps_rsp_t rsp;
  } stim_row_t;

  stim_row_t rows[$];

  // Return the ready slot with the largest positive budget, lowest id on ties;
  // MAX_PROCESSES when none qualifies.
  function automatic int best_ready();
    int    best;
    prio_t best_b;
    best   = MAX_PROCESSES;
    best_b = '0;
    for (int i = 0; i < MAX_PROCESSES; i++) begin
      if (tbl_valid[i] && tbl_state[i] == RS_READY && tbl_budget[i] > best_b) begin
        best_b = tbl_budget[i];
        best   = i;
      end
    end
    return best;
  endfunction

  // Park the current slot, pick a winner, refill the epoch once if nobody
  // has budget left, and make the winner current.
  function automatic bit run_schedule(logic [1:0] cur_rs);
    int w;
    if (tbl_valid[tbl_cur]) tbl_state[tbl_cur] = cur_rs;
    w = best_ready();
    if (w == MAX_PROCESSES) begin
      for (int i = 0; i < MAX_PROCESSES; i++)
        if (tbl_valid[i] && tbl_state[i] == RS_READY) tbl_budget[i] = tbl_prio[i];
      w = best_ready();
    end
    if (w == MAX_PROCESSES) return 1'b0;
    tbl_cur      = slot_id_t'(w);
    tbl_state[w] = RS_RUN;
    return 1'b1;
  endfunction

  function automatic prio_t cur_budget();
    return tbl_valid[tbl_cur] ? tbl_budget[tbl_cur] : '0;
  endfunction

  function automatic void free_slot(slot_id_t s);
    tbl_valid[s]  = 1'b0;
    tbl_state[s]  = RS_READY;
    tbl_prio[s]   = '0;
    tbl_budget[s] = '0;
  endfunction

  // Apply one request to the mirror; return 1 with the response it owes.
  function automatic bit apply_request(input tbps_req_t r, output tbps_rsp_t o);
    logic [1:0] rs;
    slot_id_t   tgt;
    prio_t      pr;
    bit         found;
    rs  = (r.run_state_in > RS_RUN) ? RS_RUN : r.run_state_in;
    tgt = r.target_id;
    pr  = r.new_priority;
    o   = '0;
    case (r.action)
      ACT_CREATE: begin
        for (int i = 1; i < MAX_PROCESSES; i++) begin
          if (!tbl_valid[i]) begin
            tbl_valid[i]  = 1'b1;
            tbl_state[i]  = RS_READY;
            tbl_prio[i]   = pr;
            tbl_budget[i] = pr;
            o.status        = STS_OK;
            o.result_id     = 6'(i);
            o.result_budget = pr;
            return 1'b1;
          end
        end
        o.status = STS_FULL;
        return 1'b1;
      end
      ACT_REMOVE: begin
        if (!tbl_valid[tgt]) begin
          o.status = STS_NO_PROC;
        end else if (tgt == tbl_cur) begin
          // Reschedule away from the slot first, then drop it.
          found = run_schedule(RS_RUN);
          free_slot(tgt);
          o.status        = found ? STS_CUR_REMOVE : STS_NO_READY;
          o.result_id     = tbl_cur;
          o.result_budget = found ? cur_budget() : '0;
        end else begin
          free_slot(tgt);
          o.status    = STS_OK;
          o.result_id = tgt;
        end
        return 1'b1;
      end
      ACT_SET_STATE: begin
        if (!tbl_valid[tgt]) begin
          o.status = STS_NO_PROC;
        end else begin
          tbl_state[tgt]  = rs;
          o.status        = STS_OK;
          o.result_id     = tgt;
          o.result_budget = tbl_budget[tgt];
        end
        return 1'b1;
      end
      ACT_SCHEDULE: begin
        found           = run_schedule(rs);
        o.status        = found ? STS_OK : STS_NO_READY;
        o.result_id     = tbl_cur;
        o.result_budget = cur_budget();
        return 1'b1;
      end
      ACT_CHARGE: begin
        if (tbl_valid[tbl_cur]) begin
          if (tbl_budget[tbl_cur] != '0) tbl_budget[tbl_cur] = tbl_budget[tbl_cur] - 1'b1;
          o.status        = STS_OK;
          o.result_id     = tbl_cur;
          o.result_budget = tbl_budget[tbl_cur];
        end else begin
          o.status = STS_NO_PROC;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_row(logic [2:0] act, int tgt, int prio, logic [1:0] rs,
                         bit typed, logic [2:0] sts, int id, int bud);
    stim_row_t row;
    row.req.action        = act;
    row.req.target_id     = 6'(tgt);
    row.req.new_priority  = 8'(prio);
    row.req.run_state_in  = rs;
    row.typed             = typed;
    row.rsp.status        = sts;
    row.rsp.result_id     = 6'(id);
    row.rsp.result_budget = 8'(bud);
    rows.push_back(row);
  endtask

  // Mostly aim at live slots, sometimes the current one, sometimes anywhere.
  function automatic slot_id_t pick_target();
    int k;
    int start;
    k     = $urandom_range(0, 99);
    start = $urandom_range(0, MAX_PROCESSES - 1);
    if (k < 12) return tbl_cur;
    if (k < 22) return slot_id_t'(start);
    for (int j = 0; j < MAX_PROCESSES; j++)
      if (tbl_valid[(start + j) % MAX_PROCESSES])
        return slot_id_t'((start + j) % MAX_PROCESSES);
    return slot_id_t'(start);
  endfunction

  function automatic tbps_req_t gen_request(int mix);
    tbps_req_t r;
    int        k;
    int        t_cr, t_rm, t_ss, t_sc, t_ch;
    case (mix)
      MIX_FILL:  begin t_cr = 70; t_rm = 73; t_ss = 78; t_sc = 88; t_ch = 98; end
      MIX_DRAIN: begin t_cr = 5;  t_rm = 50; t_ss = 60; t_sc = 80; t_ch = 98; end
      default:   begin t_cr = 18; t_rm = 28; t_ss = 43; t_sc = 68; t_ch = 98; end
    endcase
    k = $urandom_range(0, 99);
    if      (k < t_cr) r.action = ACT_CREATE;
    else if (k < t_rm) r.action = ACT_REMOVE;
    else if (k < t_ss) r.action = ACT_SET_STATE;
    else if (k < t_sc) r.action = ACT_SCHEDULE;
    else if (k < t_ch) r.action = ACT_CHARGE;
    else               r.action = 3'($urandom_range(ACT_IGNORED_LO, ACT_IGNORED_HI));
    r.target_id = pick_target();
    // Small priorities keep budgets running dry, so epochs roll over often.
    k = $urandom_range(0, 99);
    if      (k < 55) r.new_priority = 8'($urandom_range(0, 7));
    else if (k < 62) r.new_priority = 8'hFF;
    else if (k < 67) r.new_priority = 8'h00;
    else             r.new_priority = 8'($urandom_range(0, 255));
    r.run_state_in = ($urandom_range(0, 1) == 0) ? RS_READY : 2'($urandom_range(0, 3));
    return r;
  endfunction

  // Offer one request, hold it until accepted, then record what it owes.
  task automatic send(input tbps_req_t r, input bit typed, input tbps_rsp_t typed_rsp);
    tbps_rsp_t p;
    bit        has;
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    has = apply_request(r, p);
    if (has) rsp_due_q.push_back(typed ? typed_rsp : p);
  endtask

  // Idle between bursts; keep valid up inside a burst.
  task automatic burst_gap(bit steady);
    int gap;
    if (steady) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    gap        = $urandom_range(1, 12);
    burst_left = $urandom_range(0, 24);
    in_valid  <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  // Drop valid and hold until the block owes nothing.
  task automatic drain_pause();
    in_valid <= 1'b0;
    while (rsp_due_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  initial begin
    tbps_req_t r;
    int        mix;
    int        n;
    in_valid <= 1'b0;
    in_req   <= '0;
    rst_n    <= 1'b0;

    for (int i = 0; i < MAX_PROCESSES; i++) begin
      tbl_valid[i]  = 1'b0;
      tbl_state[i]  = RS_READY;
      tbl_prio[i]   = '0;
      tbl_budget[i] = '0;
    end
    tbl_valid[0]  = 1'b1;
    tbl_state[0]  = RS_RUN;
    tbl_prio[0]   = prio_t'(1);
    tbl_budget[0] = prio_t'(1);
    tbl_cur       = '0;

    // Directed walk: after reset slot 0 runs with one tick.
    add_row(ACT_CHARGE,     0,   0,   RS_READY, 1, STS_OK,       0, 0);
    add_row(ACT_SCHEDULE,   0,   0,   RS_READY, 1, STS_OK,       0, 1);  // refill
    add_row(ACT_CREATE,     0,   255, RS_READY, 1, STS_OK,       1, 255);
    add_row(ACT_CREATE,     0,   0,   RS_READY, 1, STS_OK,       2, 0);
    add_row(ACT_SET_STATE,  63,  0,   RS_READY, 1, STS_NO_PROC,  0, 0);
    add_row(ACT_REMOVE,     40,  0,   RS_READY, 1, STS_NO_PROC,  0, 0);
    add_row(ACT_SET_STATE,  2,   0,   RS_OVER,  1, STS_OK,       2, 0);  // saturates
    add_row(ACT_SCHEDULE,   0,   0,   RS_SLEEP, 0, STS_OK,       0, 0);
    add_row(ACT_CHARGE,     0,   0,   RS_READY, 0, STS_OK,       0, 0);
    add_row(ACT_CREATE,     0,   7,   RS_READY, 0, STS_OK,       0, 0);
    add_row(ACT_REMOVE,     3,   0,   RS_READY, 0, STS_OK,       0, 0);
    // Remove the running slot with nobody ready: current stays on the freed id.
    add_row(ACT_REMOVE,     1,   0,   RS_READY, 1, STS_NO_READY, 1, 0);
    add_row(ACT_CHARGE,     0,   0,   RS_READY, 1, STS_NO_PROC,  0, 0);
    add_row(ACT_SCHEDULE,   0,   0,   RS_READY, 1, STS_NO_READY, 1, 0);
    add_row(ACT_SET_STATE,  0,   0,   RS_READY, 0, STS_OK,       0, 0);
    add_row(ACT_SCHEDULE,   0,   0,   RS_RUN,   0, STS_OK,       0, 0);
    add_row(ACT_IGNORED_LO, 0,   0,   RS_READY, 0, STS_OK,       0, 0);
    add_row(ACT_IGNORED_HI, 63,  255, RS_OVER,  0, STS_OK,       0, 0);
    add_row(ACT_CREATE,     0,   128, RS_READY, 0, STS_OK,       0, 0);
    add_row(ACT_SET_STATE,  2,   0,   RS_READY, 0, STS_OK,       0, 0);
    // Remove the running slot with a ready successor.
    add_row(ACT_REMOVE,     0,   0,   RS_READY, 0, STS_OK,       0, 0);
    add_row(ACT_SCHEDULE,   0,   0,   RS_OVER,  0, STS_OK,       0, 0);
    add_row(ACT_CHARGE,     0,   0,   RS_READY, 0, STS_OK,       0, 0);
    add_row(3'd6,           21,  85,  RS_SLEEP, 0, STS_OK,       0, 0);
    add_row(ACT_CREATE,     0,   1,   RS_READY, 0, STS_OK,       0, 0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < rows.size(); i++) begin
      send(rows[i].req, rows[i].typed, rows[i].rsp);
      if (i == rows.size() - 1) drain_pause();
      else                      burst_gap(1'b0);
    end

    // Random chunks: fill the table, drain it, and plain traffic in between.
    for (int c = 0; c < CHUNKS; c++) begin
      mix = (c == 2 || c == 3 || c == 7) ? MIX_FILL :
            (c == 5 || c == 9)           ? MIX_DRAIN : MIX_NORMAL;
      n = 0;
      while (n < CHUNK_ITEMS) begin
        r = gen_request(mix);
        if (r.action <= ACT_CHARGE) n++;
        send(r, 1'b0, '0);
        if (n == CHUNK_ITEMS) drain_pause();
        else                  burst_gap(c == 4 || c == 8);
      end
    end

    // Let anything an ignored request might stir up show itself.
    repeat (300) @(posedge clk);
    if (err_count == 0 && rsp_due_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Response side: stall in windows of random mode, and once hold off long
  // enough that the block backs up into its request port.
  // ---------------------------------------------------------------------------
  initial begin
    int win_left;
    int mode;
    int hold_left;
    int cyc;
    bit held_once;
    win_left  = 0;
    mode      = 0;
    hold_left = 0;
    cyc       = 0;
    held_once = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      cyc++;
      if (!held_once && rx_count >= 250) begin
        held_once = 1'b1;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (win_left == 0) begin
          mode     = $urandom_range(0, 3);
          win_left = $urandom_range(16, 96);
        end
        win_left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 4) != 0);
          default: out_ready <= (cyc % 7 > 2);
        endcase
      end
    end
  end

  // Compare each accepted response with the oldest one owed.
  always @(posedge clk) begin
    tbps_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      rx_count <= rx_count + 1;
      if (rsp_due_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected response: status %0d id %0d budget %0d",
                   out_rsp.status, out_rsp.result_id, out_rsp.result_budget);
      end else begin
        want = rsp_due_q.pop_front();
        if (out_rsp.status != want.status || out_rsp.result_id != want.result_id ||
            out_rsp.result_budget != want.result_budget) begin
          err_count++;
          if (err_count <= 10)
            $display("response mismatch: want status %0d id %0d budget %0d, got %0d %0d %0d",
                     want.status, want.result_id, want.result_budget,
                     out_rsp.status, out_rsp.result_id, out_rsp.result_budget);
        end
      end
    end
  end

endmodule

@@ files.f @@
rtl/core/tbps_pkg.sv
rtl/core/tbps_slot_store.sv
rtl/core/tick_budget_process_scheduler_top.sv
tb/sv/tb_tick_budget_process_scheduler_top.sv
